// ----- design/snapshot_version_store_unit_macros.svh -----
// Assertion macros used by the snapshot version store controller.
`ifndef SNAPSHOT_VERSION_STORE_UNIT_MACROS_SVH
`define SNAPSHOT_VERSION_STORE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SVS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SVS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/svs_pkg.sv -----
// Shared constants and controller/datapath types for the snapshot version store.
`default_nettype none
package svs_pkg;

    localparam int REPLICAS_DEF = 4;
    localparam int VERSIONS_DEF = 16;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_DROPPED  = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_HIT      = 3'd3;
    localparam logic [2:0] ST_MISS     = 3'd4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic capture;
        logic ins_commit;
        logic scan_clear;
        logic scan_next_rep;
        logic scan_eval;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic rep_done;
        logic rep_empty;
    } sts_t;

endpackage
`default_nettype wire

// ----- design/svs_datapath.sv -----
// Datapath: version memory, stack pointers, scan registers and result register.
`default_nettype none
module svs_datapath #(
    parameter int REPLICAS             = svs_pkg::REPLICAS_DEF,
    parameter int VERSIONS_PER_REPLICA = svs_pkg::VERSIONS_DEF
) (
    input  wire                logic        clk,
    input  wire                logic        rst_n,
    input  wire                svs_pkg::cmd_t cmd,
    output svs_pkg::sts_t                   sts,
    input  wire                logic        cfg_we,
    input  wire                logic [1:0]  cfg_data,
    input  wire                logic        in_op,
    input  wire                logic [1:0]  in_src,
    input  wire                logic [63:0] in_ut,
    input  wire                logic [63:0] in_rst,
    input  wire                logic [31:0] in_val,
    input  wire                logic [63:0] in_snl,
    input  wire                logic [63:0] in_snr,
    output logic [2:0]                      res_status,
    output logic [31:0]                     res_value,
    output logic [63:0]                     res_time,
    output logic [1:0]                      res_replica
);
    localparam int V     = VERSIONS_PER_REPLICA;
    localparam int RW    = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
    localparam int RCW   = $clog2(REPLICAS + 1);
    localparam int IW    = (V > 1) ? $clog2(V) : 1;
    localparam int CW    = $clog2(V + 1);
    localparam int DEPTH = REPLICAS * V;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [63:0] ut;
        logic [63:0] st;
        logic [31:0] val;
    } entry_t;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    logic [1:0]  local_replica_reg;
    logic        is_read_reg;
    logic [1:0]  src_reg;
    logic [63:0] ut_reg;
    logic [63:0] rst_reg;
    logic [31:0] val_reg;
    logic [63:0] snl_reg;
    logic [63:0] snr_reg;

    logic [IW-1:0] top_reg  [REPLICAS];
    logic [CW-1:0] fill_reg [REPLICAS];

    logic [RCW-1:0] r_reg;
    logic [CW-1:0]  k_reg;
    logic           have_reg;
    logic [63:0]    best_t_reg;
    logic [31:0]    best_val_reg;
    logic [RW-1:0]  best_r_reg;
    logic [2:0]     ins_status_reg;

    logic [2:0]     res_status_reg;
    logic [31:0]    res_value_reg;
    logic [63:0]    res_time_reg;
    logic [1:0]     res_replica_reg;

    logic [RW-1:0] sel_r;
    logic [IW-1:0] top_sel;
    logic [CW-1:0] fill_sel;
    logic [CW-1:0] k_eff;
    logic [CW:0]   t_ext;
    logic [CW:0]   k_ext;
    logic [IW-1:0] slot;
    logic [IW-1:0] top_next;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          src_bad;
    logic          reject;
    logic          is_local;
    logic          visible;
    logic          mem_we;

    always_comb
    begin
        sel_r    = is_read_reg ? RW'(r_reg) : RW'(src_reg);
        top_sel  = top_reg[sel_r];
        fill_sel = fill_reg[sel_r];
        k_eff    = is_read_reg ? k_reg : '0;
        t_ext    = (CW + 1)'(top_sel);
        k_ext    = (CW + 1)'(k_eff);
        if (t_ext >= k_ext)
        begin
            slot = IW'(t_ext - k_ext);
        end
        else
        begin
            slot = IW'(t_ext + (CW + 1)'(V) - k_ext);
        end
        top_next = (top_sel == IW'(V - 1)) ? '0 : IW'(top_sel + 1'b1);
        raddr    = AW'(int'(sel_r) * V + int'(slot));
        waddr    = AW'(int'(sel_r) * V + int'(top_next));
        src_bad  = int'(src_reg) >= REPLICAS;
        reject   = src_bad || ((fill_sel != '0) && (ut_reg < rdata_reg.ut));
        mem_we   = cmd.ins_commit && !reject;
        is_local = int'(local_replica_reg) == int'(r_reg);
        if (is_local)
        begin
            visible = (rdata_reg.ut <= snl_reg) && (rdata_reg.st <= snr_reg);
        end
        else
        begin
            visible = (rdata_reg.ut <= snr_reg) && (rdata_reg.st <= snl_reg);
        end
        sts.rep_done  = r_reg == RCW'(REPLICAS);
        sts.rep_empty = k_reg >= fill_sel;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= '{ut: ut_reg, st: rst_reg, val: val_reg};
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_replica_reg <= '0;
            for (int i = 0; i < REPLICAS; i++)
            begin
                top_reg[i]  <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                local_replica_reg <= cfg_data;
            end
            if (mem_we)
            begin
                top_reg[sel_r] <= top_next;
                if (int'(fill_sel) < V)
                begin
                    fill_reg[sel_r] <= CW'(fill_sel + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_read_reg <= in_op == svs_pkg::OP_READ;
            src_reg     <= in_src;
            ut_reg      <= in_ut;
            rst_reg     <= in_rst;
            val_reg     <= in_val;
            snl_reg     <= in_snl;
            snr_reg     <= in_snr;
        end
        if (cmd.ins_commit)
        begin
            if (reject)
            begin
                ins_status_reg <= svs_pkg::ST_REJECTED;
            end
            else if (int'(fill_sel) >= V)
            begin
                ins_status_reg <= svs_pkg::ST_DROPPED;
            end
            else
            begin
                ins_status_reg <= svs_pkg::ST_INSERTED;
            end
        end
        if (cmd.scan_clear)
        begin
            r_reg    <= '0;
            k_reg    <= '0;
            have_reg <= 1'b0;
        end
        else if (cmd.scan_next_rep)
        begin
            r_reg <= RCW'(r_reg + 1'b1);
            k_reg <= '0;
        end
        else if (cmd.scan_eval)
        begin
            if (visible)
            begin
                if (!have_reg || (rdata_reg.ut > best_t_reg))
                begin
                    have_reg     <= 1'b1;
                    best_t_reg   <= rdata_reg.ut;
                    best_val_reg <= rdata_reg.val;
                    best_r_reg   <= RW'(r_reg);
                end
                r_reg <= RCW'(r_reg + 1'b1);
                k_reg <= '0;
            end
            else
            begin
                k_reg <= CW'(k_reg + 1'b1);
            end
        end
        if (cmd.out_load)
        begin
            if (!is_read_reg)
            begin
                res_status_reg  <= ins_status_reg;
                res_value_reg   <= '0;
                res_time_reg    <= '0;
                res_replica_reg <= '0;
            end
            else if (have_reg)
            begin
                res_status_reg  <= svs_pkg::ST_HIT;
                res_value_reg   <= best_val_reg;
                res_time_reg    <= best_t_reg;
                res_replica_reg <= 2'(best_r_reg);
            end
            else
            begin
                res_status_reg  <= svs_pkg::ST_MISS;
                res_value_reg   <= '0;
                res_time_reg    <= '0;
                res_replica_reg <= '0;
            end
        end
    end

    assign res_status  = res_status_reg;
    assign res_value   = res_value_reg;
    assign res_time    = res_time_reg;
    assign res_replica = res_replica_reg;
endmodule
`default_nettype wire

// ----- design/svs_ctrl.sv -----
// Controller: sequences inserts and snapshot scans and owns both handshakes.
`default_nettype none
`include "snapshot_version_store_unit_macros.svh"
module svs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_op,
    output logic               out_valid,
    input  wire logic          out_ready,
    output svs_pkg::cmd_t      cmd,
    input  wire svs_pkg::sts_t sts
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INS_RD = 3'd1;
    localparam logic [2:0] S_INS_WR = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_EVAL   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        in_ready       = state_reg == S_IDLE;
        accept         = in_valid && in_ready;
        out_free       = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    if (in_op == svs_pkg::OP_READ)
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_INS_RD;
                    end
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                cmd.ins_commit = 1'b1;
                state_next     = S_FIN;
            end
            S_SCAN:
            begin
                priority if (sts.rep_done)
                begin
                    state_next = S_FIN;
                end
                else if (sts.rep_empty)
                begin
                    cmd.scan_next_rep = 1'b1;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.scan_eval = 1'b1;
                state_next    = S_SCAN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `SVS_ASSERT_NXT(a_fin_loads, (state_reg == S_FIN) && out_free, out_valid_reg,
        "result not presented")
    `SVS_ASSERT_NXT(a_accept_busy, accept, state_reg != S_IDLE,
        "block idle after a transaction")
    `SVS_ASSERT_IMP(a_eval_after_scan, state_reg == S_EVAL, $past(state_reg) == S_SCAN,
        "eval without read")
    `SVS_ASSERT_IMP(a_one_cmd, 1'b1,
        $onehot0({cmd.ins_commit, cmd.scan_next_rep, cmd.scan_eval, cmd.out_load}),
        "command overlap")
endmodule
`default_nettype wire

// ----- design/snapshot_version_store_unit.sv -----
// Top level of the snapshot version store: controller plus datapath.
//
// Channel   Handshake              Payload
// input     in_valid / in_ready    op, src_replica, update_time, remote_stable_time,
//                                  value_handle, snap_local_time, snap_remote_time
// output    out_valid / out_ready  status, out_value, out_time, out_replica
// config    cfg_valid / cfg_ready  local_replica
//
// An insert's result is presented after a head read from the version memory, a compare
// and write, then the output register load.
// A read scans each replica's stack from its newest entry; each entry costs one memory
// read and one evaluation, and a replica's scan stops at its first visible entry.
// One transaction is in flight at a time; a new one is taken while a result still waits.
// Reset empties every stack at once; memory contents are not cleared.
`default_nettype none
module snapshot_version_store_unit #(
    parameter int REPLICAS             = svs_pkg::REPLICAS_DEF,
    parameter int VERSIONS_PER_REPLICA = svs_pkg::VERSIONS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [1:0]  src_replica,
    input  wire logic [63:0] update_time,
    input  wire logic [63:0] remote_stable_time,
    input  wire logic [31:0] value_handle,
    input  wire logic [63:0] snap_local_time,
    input  wire logic [63:0] snap_remote_time,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      out_value,
    output logic [63:0]      out_time,
    output logic [1:0]       out_replica,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  local_replica
);
    svs_pkg::cmd_t cmd;
    svs_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    svs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    svs_datapath #(
        .REPLICAS             (REPLICAS),
        .VERSIONS_PER_REPLICA (VERSIONS_PER_REPLICA)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (local_replica),
        .in_op       (op),
        .in_src      (src_replica),
        .in_ut       (update_time),
        .in_rst      (remote_stable_time),
        .in_val      (value_handle),
        .in_snl      (snap_local_time),
        .in_snr      (snap_remote_time),
        .res_status  (status),
        .res_value   (out_value),
        .res_time    (out_time),
        .res_replica (out_replica)
    );
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the snapshot version store: directed and random tests.
`timescale 1ns / 1ps
module tb_top;
    localparam int NREP = 4;
    localparam int DEPTH = 16;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] val;
        logic [63:0] tm;
        logic [1:0]  rep;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = svs_pkg::OP_INSERT;
    logic [1:0]  src_replica = '0;
    logic [63:0] update_time = '0;
    logic [63:0] remote_stable_time = '0;
    logic [31:0] value_handle = '0;
    logic [63:0] snap_local_time = '0;
    logic [63:0] snap_remote_time = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] out_value;
    logic [63:0] out_time;
    logic [1:0]  out_replica;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  local_replica = '0;

    snapshot_version_store_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .src_replica(src_replica),
        .update_time(update_time), .remote_stable_time(remote_stable_time),
        .value_handle(value_handle), .snap_local_time(snap_local_time),
        .snap_remote_time(snap_remote_time),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .out_value(out_value), .out_time(out_time), .out_replica(out_replica),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .local_replica(local_replica)
    );

    always #6 clk = ~clk;

    logic [63:0] hist_ut [NREP][DEPTH];
    logic [63:0] hist_st [NREP][DEPTH];
    logic [31:0] hist_val [NREP][DEPTH];
    int          head_slot [NREP];
    int          fill_cnt [NREP];
    logic [1:0]  home_replica;
    verdict_t    pending_verdicts[$];
    int          error_count = 0;
    int          result_count = 0;
    int          read_count = 0;
    int          hit_count = 0;
    int          drop_count = 0;
    int          reject_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    longint      cycle_count = 0;
    logic [63:0] tbase [NREP];

    function automatic int slot_at(int r, int k);
        return (head_slot[r] + DEPTH - k) % DEPTH;
    endfunction

    function automatic verdict_t predict_version(logic o, logic [1:0] r, logic [63:0] ut,
            logic [63:0] rst, logic [31:0] v, logic [63:0] sl, logic [63:0] sr);
        verdict_t res;
        int pos [NREP];
        int best;
        logic [63:0] best_t;
        logic [63:0] t;
        int s;
        bit have;
        bit vis;
        res = '0;
        if (o == svs_pkg::OP_INSERT)
        begin
            if (fill_cnt[r] > 0 && ut < hist_ut[r][head_slot[r]])
            begin
                res.st = svs_pkg::ST_REJECTED;
                return res;
            end
            head_slot[r] = (head_slot[r] + 1) % DEPTH;
            if (fill_cnt[r] >= DEPTH)
            begin
                res.st = svs_pkg::ST_DROPPED;
            end
            else
            begin
                res.st = svs_pkg::ST_INSERTED;
                fill_cnt[r]++;
            end
            hist_ut[r][head_slot[r]] = ut;
            hist_st[r][head_slot[r]] = rst;
            hist_val[r][head_slot[r]] = v;
            return res;
        end
        for (int i = 0; i < NREP; i++) pos[i] = 0;
        forever
        begin
            have = 0;
            best = 0;
            best_t = '0;
            for (int i = 0; i < NREP; i++)
            begin
                if (pos[i] < fill_cnt[i])
                begin
                    t = hist_ut[i][slot_at(i, pos[i])];
                    if (!have || best_t < t)
                    begin
                        have = 1;
                        best = i;
                        best_t = t;
                    end
                end
            end
            if (!have)
            begin
                res.st = svs_pkg::ST_MISS;
                return res;
            end
            s = slot_at(best, pos[best]);
            if (best == int'(home_replica))
                vis = hist_ut[best][s] <= sl && hist_st[best][s] <= sr;
            else
                vis = hist_ut[best][s] <= sr && hist_st[best][s] <= sl;
            if (vis)
            begin
                res.st = svs_pkg::ST_HIT;
                res.val = hist_val[best][s];
                res.tm = hist_ut[best][s];
                res.rep = best[1:0];
                return res;
            end
            pos[best]++;
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        verdict_t w;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                if (pending_verdicts.size() == 0)
                begin
                    report_mismatch("unexpected result transaction, status", 64'(status),
                                    64'(0));
                end
                else
                begin
                    w = pending_verdicts.pop_front();
                    if (status !== w.st)
                        report_mismatch("status", 64'(status), 64'(w.st));
                    if (out_value !== w.val)
                        report_mismatch("out_value", 64'(out_value), 64'(w.val));
                    if (out_time !== w.tm)
                        report_mismatch("out_time", out_time, w.tm);
                    if (out_replica !== w.rep)
                        report_mismatch("out_replica", 64'(out_replica), 64'(w.rep));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(logic o, logic [1:0] r, logic [63:0] ut, logic [63:0] rst,
            logic [31:0] v, logic [63:0] sl, logic [63:0] sr);
        verdict_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        src_replica <= r;
        update_time <= ut;
        remote_stable_time <= rst;
        value_handle <= v;
        snap_local_time <= sl;
        snap_remote_time <= sr;
        do @(posedge clk); while (!in_ready);
        w = predict_version(o, r, ut, rst, v, sl, sr);
        if (o == svs_pkg::OP_READ)
        begin
            read_count++;
            if (w.st == svs_pkg::ST_HIT) hit_count++;
        end
        else if (w.st == svs_pkg::ST_DROPPED) drop_count++;
        else if (w.st == svs_pkg::ST_REJECTED) reject_count++;
        pending_verdicts = {pending_verdicts, w};
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_home_replica(logic [1:0] r);
        drain_results();
        cfg_valid <= 1'b1;
        local_replica <= r;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        home_replica = r;
    endtask

    task automatic test_directed();
        logic [63:0] mx;
        mx = '1;
        send_item(svs_pkg::OP_READ, 2'd0, '0, '0, '0, mx, mx);
        send_item(svs_pkg::OP_INSERT, 2'd0, 64'd100, 64'd50, 32'hFFFF_FFFF, '0, '0);
        send_item(svs_pkg::OP_INSERT, 2'd0, 64'd90, 64'd0, 32'h1, '0, '0);
        send_item(svs_pkg::OP_INSERT, 2'd0, 64'd100, 64'd60, 32'h2, '0, '0);
        send_item(svs_pkg::OP_INSERT, 2'd1, 64'd100, 64'd10, 32'h3, '0, '0);
        send_item(svs_pkg::OP_INSERT, 2'd3, mx, mx, 32'h0, '0, '0);
        send_item(svs_pkg::OP_INSERT, 2'd2, '0, '0, 32'h5, '0, '0);
        send_item(svs_pkg::OP_READ, 2'd3, '0, '0, '0, mx, mx);
        send_item(svs_pkg::OP_READ, 2'd0, '0, '0, '0, 64'd100, 64'd100);
        send_item(svs_pkg::OP_READ, 2'd0, '0, '0, '0, 64'd100, 64'd55);
        send_item(svs_pkg::OP_READ, 2'd0, '0, '0, '0, 64'd5, 64'd100);
        send_item(svs_pkg::OP_READ, 2'd0, '0, '0, '0, '0, '0);
        for (int i = 0; i < DEPTH + 3; i++)
            send_item(svs_pkg::OP_INSERT, 2'd2, 64'd10 + 64'(i), 64'd1, 32'hA00 + 32'(i),
                      '0, '0);
        send_item(svs_pkg::OP_READ, 2'd0, '0, '0, '0, 64'd11, 64'd11);
    endtask

    task automatic random_phase(int n);
        logic [1:0] r;
        logic [63:0] sl;
        logic [63:0] sr;
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            r = 2'($urandom_range(3));
            if (k < 5)
            begin
                send_item(1'($urandom_range(1)), r, {$urandom, $urandom},
                          {$urandom, $urandom}, $urandom, {$urandom, $urandom},
                          {$urandom, $urandom});
            end
            else if (k < 55)
            begin
                tbase[r] = tbase[r] + 64'($urandom_range(3));
                if ($urandom_range(9) == 0)
                    send_item(svs_pkg::OP_INSERT, r, tbase[r] - 64'($urandom_range(5)),
                              64'($urandom_range(400)), $urandom, '0, '0);
                else
                    send_item(svs_pkg::OP_INSERT, r, tbase[r],
                              tbase[r] - 64'($urandom_range(60)), $urandom, '0, '0);
            end
            else
            begin
                sl = tbase[$urandom_range(3)] - 64'($urandom_range(30));
                sr = tbase[$urandom_range(3)] - 64'($urandom_range(30));
                if ($urandom_range(15) == 0) sl = '1;
                send_item(svs_pkg::OP_READ, r, '0, '0, '0, sl, sr);
            end
            if (i == n / 2) drain_results();
        end
    endtask

    task automatic test_random();
        for (int r = 0; r < NREP; r++) tbase[r] = 64'd200 + 64'($urandom_range(100));
        send_idle_pct = 16;
        recv_idle_pct = 74;
        random_phase(600);
        set_home_replica(2'd3);
        send_idle_pct = 74;
        recv_idle_pct = 16;
        random_phase(600);
        set_home_replica(2'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(300);
        set_home_replica(2'd2);
        random_phase(300);
    endtask

    initial
    begin
        for (int r = 0; r < NREP; r++)
        begin
            head_slot[r] = 0;
            fill_cnt[r] = 0;
        end
        home_replica = 2'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_home_replica(2'd0);
        test_directed();
        set_home_replica(2'd3);
        send_item(svs_pkg::OP_READ, 2'd0, '0, '0, '0, 64'd100, 64'd100);
        set_home_replica(2'd0);
        test_random();
        drain_results();
        $display("Covered %0d results: %0d reads (%0d hits), %0d drops, %0d rejects,",
                 result_count, read_count, hit_count, drop_count, reject_count);
        $display("over four home replica settings and three idling patterns.");
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
